// ===== hw/rtl/bsfr_pkg.sv =====
package bsfr_pkg;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_STATION_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME_BITS  = 2'd1;

    localparam logic [10:0] MIN_FRAME_BITS_RESET = 11'd160;

    // flag tracker: 8 means the whole 01111110 pattern has been seen
    localparam logic [3:0] FLAG_DONE = 4'd8;

    // delay line depth keeping the closing flag away from the destuffer
    localparam logic [2:0] DELAY_FULL = 3'd7;

    localparam logic [2:0]  ONES_SAT   = 3'd7;
    localparam logic [2:0]  ONES_STUFF = 3'd5;
    localparam logic [2:0]  BIT_LAST   = 3'd7;
    localparam logic [10:0] STUFFED_SAT = 11'h7FF;
    localparam int unsigned ADDR_BYTES = 6;

    // result kinds
    localparam logic RK_DATA   = 1'b0;
    localparam logic RK_STATUS = 1'b1;

    // frame status codes
    localparam logic [2:0] ST_GOOD        = 3'd0;
    localparam logic [2:0] ST_TRAILER_NZ  = 3'd1;
    localparam logic [2:0] ST_ADDR_MISS   = 3'd2;
    localparam logic [2:0] ST_TOO_SHORT   = 3'd4;
    localparam logic [2:0] ST_OVERFLOW    = 3'd5;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] data_byte;
        logic [6:0] byte_index;
        logic [2:0] frame_status;
        logic [7:0] frame_bytes;
    } t_result;

    // positions 0 and 7 want a zero, 1..6 want a one
    function automatic logic [3:0] flag_track(input logic [3:0] pos, input logic b);
        logic [3:0] nxt;
        if (pos == 4'd0 || pos == 4'd7) begin
            nxt = !b ? pos + 4'd1 : 4'd0;
        end else begin
            nxt = b ? pos + 4'd1 : 4'd1;
        end
        return nxt;
    endfunction

    // byte i of the station address, byte 0 most significant
    function automatic logic [7:0] addr_byte(input logic [CFG_DATA_W-1:0] addr,
                                             input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0:    val = addr[47:40];
            3'd1:    val = addr[39:32];
            3'd2:    val = addr[31:24];
            3'd3:    val = addr[23:16];
            3'd4:    val = addr[15:8];
            3'd5:    val = addr[7:0];
            default: val = 8'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== hw/rtl/bsfr_ifs.sv =====
interface bsfr_bit_if;
    logic valid;
    logic ready;
    logic line_bit;

    modport source (output valid, output line_bit, input ready);
    modport sink   (input valid, input line_bit, output ready);
endinterface

interface bsfr_res_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] data_byte;
    logic [6:0] byte_index;
    logic [2:0] frame_status;
    logic [7:0] frame_bytes;

    modport source (output valid, output result_kind, output data_byte,
                    output byte_index, output frame_status, output frame_bytes,
                    input ready);
    modport sink   (input valid, input result_kind, input data_byte,
                    input byte_index, input frame_status, input frame_bytes,
                    output ready);
endinterface

interface bsfr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bsfr_pkg::CFG_IDX_W-1:0]    index;
    logic [bsfr_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/bsfr_deframer.sv =====
module bsfr_deframer #(
    parameter int unsigned MAX_FRAME_BYTES = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic                            i_line_bit,
    input  logic [bsfr_pkg::CFG_DATA_W-1:0] i_station_address,
    input  logic [10:0]                     i_min_frame_bits,
    output logic                            o_res_valid,
    output bsfr_pkg::t_result               o_res
);

    // byte count runs to MAX_FRAME_BYTES + 1, which marks overflow
    localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 2);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME_BYTES);
    localparam logic [CW-1:0] CNT_OVF = CW'(MAX_FRAME_BYTES + 1);
    localparam int unsigned ADDR_BYTES_L = bsfr_pkg::ADDR_BYTES;

    logic [3:0]    r_open_match,    n_open_match;
    logic [3:0]    r_close_match,   n_close_match;
    logic [6:0]    r_flag_delay,    n_flag_delay;
    logic [2:0]    r_delay_fill,    n_delay_fill;
    logic [2:0]    r_ones_run,      n_ones_run;
    logic [7:0]    r_byte_shift,    n_byte_shift;
    logic [2:0]    r_bit_in_byte,   n_bit_in_byte;
    logic [CW-1:0] r_byte_count,    n_byte_count;
    logic [10:0]   r_stuffed_bits,  n_stuffed_bits;
    logic          r_address_differs, n_address_differs;
    logic [31:0]   r_last_four,     n_last_four;

    logic [3:0]    close_nxt;
    logic          dbit;
    logic [7:0]    byte_nxt;
    logic          tail_diff;
    logic [CW-1:0] kept;
    logic [CW+7:0] kept_ext;
    logic [CW+7:0] idx_ext;

    // address bytes the frame never reached count against zero
    always_comb begin
        tail_diff = 1'b0;
        for (int i = 0; i < ADDR_BYTES_L; i++) begin
            if (r_byte_count <= CW'(i) &&
                bsfr_pkg::addr_byte(i_station_address, 3'(i)) != 8'd0) begin
                tail_diff = 1'b1;
            end
        end
    end

    assign kept     = (r_byte_count > CNT_MAX) ? CNT_MAX : r_byte_count;
    assign kept_ext = {8'd0, kept};
    assign idx_ext  = {8'd0, r_byte_count};
    assign close_nxt = bsfr_pkg::flag_track(r_close_match, i_line_bit);
    assign dbit      = r_flag_delay[6];
    assign byte_nxt  = {r_byte_shift[6:0], dbit};

    always_comb begin
        n_open_match      = r_open_match;
        n_close_match     = r_close_match;
        n_flag_delay      = r_flag_delay;
        n_delay_fill      = r_delay_fill;
        n_ones_run        = r_ones_run;
        n_byte_shift      = r_byte_shift;
        n_bit_in_byte     = r_bit_in_byte;
        n_byte_count      = r_byte_count;
        n_stuffed_bits    = r_stuffed_bits;
        n_address_differs = r_address_differs;
        n_last_four       = r_last_four;
        o_res_valid       = 1'b0;
        o_res             = '0;

        if (i_step) begin
            if (r_open_match != bsfr_pkg::FLAG_DONE) begin
                // hunting the opening flag
                n_open_match = bsfr_pkg::flag_track(r_open_match, i_line_bit);
                if (n_open_match == bsfr_pkg::FLAG_DONE) begin
                    n_close_match     = '0;
                    n_flag_delay      = '0;
                    n_delay_fill      = '0;
                    n_ones_run        = '0;
                    n_byte_shift      = '0;
                    n_bit_in_byte     = '0;
                    n_byte_count      = '0;
                    n_stuffed_bits    = '0;
                    n_address_differs = 1'b0;
                    n_last_four       = '0;
                end
            end else begin
                if (r_stuffed_bits < bsfr_pkg::STUFFED_SAT) begin
                    n_stuffed_bits = r_stuffed_bits + 11'd1;
                end
                n_close_match = close_nxt;

                if (close_nxt == bsfr_pkg::FLAG_DONE) begin
                    // closing flag: report and restart the frame state
                    o_res_valid            = 1'b1;
                    o_res.result_kind      = bsfr_pkg::RK_STATUS;
                    o_res.frame_bytes      = kept_ext[7:0];
                    if (n_stuffed_bits <= i_min_frame_bits) begin
                        o_res.frame_status = bsfr_pkg::ST_TOO_SHORT;
                        n_open_match       = bsfr_pkg::FLAG_DONE;
                    end else begin
                        n_open_match = '0;
                        if (r_byte_count > CNT_MAX) begin
                            o_res.frame_status = bsfr_pkg::ST_OVERFLOW;
                        end else begin
                            o_res.frame_status = bsfr_pkg::ST_GOOD
                                | ((r_last_four != 32'd0) ? bsfr_pkg::ST_TRAILER_NZ
                                                          : bsfr_pkg::ST_GOOD)
                                | ((r_address_differs || tail_diff)
                                   ? bsfr_pkg::ST_ADDR_MISS : bsfr_pkg::ST_GOOD);
                        end
                    end
                    n_close_match     = '0;
                    n_flag_delay      = '0;
                    n_delay_fill      = '0;
                    n_ones_run        = '0;
                    n_byte_shift      = '0;
                    n_bit_in_byte     = '0;
                    n_byte_count      = '0;
                    n_stuffed_bits    = '0;
                    n_address_differs = 1'b0;
                    n_last_four       = '0;
                end else if (r_delay_fill < bsfr_pkg::DELAY_FULL) begin
                    n_flag_delay = {r_flag_delay[5:0], i_line_bit};
                    n_delay_fill = r_delay_fill + 3'd1;
                end else begin
                    n_flag_delay = {r_flag_delay[5:0], i_line_bit};
                    if (dbit) begin
                        if (r_ones_run < bsfr_pkg::ONES_SAT) begin
                            n_ones_run = r_ones_run + 3'd1;
                        end
                    end else begin
                        n_ones_run = '0;
                    end
                    // a zero after exactly five ones is a stuffed bit
                    if (dbit || r_ones_run != bsfr_pkg::ONES_STUFF) begin
                        n_byte_shift = byte_nxt;
                        if (r_bit_in_byte < bsfr_pkg::BIT_LAST) begin
                            n_bit_in_byte = r_bit_in_byte + 3'd1;
                        end else begin
                            n_bit_in_byte = '0;
                            if (r_byte_count < CNT_MAX) begin
                                if (r_byte_count < CW'(ADDR_BYTES_L) &&
                                    byte_nxt != bsfr_pkg::addr_byte(i_station_address,
                                                                    idx_ext[2:0])) begin
                                    n_address_differs = 1'b1;
                                end
                                n_last_four       = {r_last_four[23:0], byte_nxt};
                                n_byte_count      = r_byte_count + CW'(1);
                                o_res_valid       = 1'b1;
                                o_res.result_kind = bsfr_pkg::RK_DATA;
                                o_res.data_byte   = byte_nxt;
                                o_res.byte_index  = idx_ext[6:0];
                            end else begin
                                n_byte_count = CNT_OVF;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_match      <= '0;
            r_close_match     <= '0;
            r_flag_delay      <= '0;
            r_delay_fill      <= '0;
            r_ones_run        <= '0;
            r_byte_shift      <= '0;
            r_bit_in_byte     <= '0;
            r_byte_count      <= '0;
            r_stuffed_bits    <= '0;
            r_address_differs <= 1'b0;
            r_last_four       <= '0;
        end else begin
            r_open_match      <= n_open_match;
            r_close_match     <= n_close_match;
            r_flag_delay      <= n_flag_delay;
            r_delay_fill      <= n_delay_fill;
            r_ones_run        <= n_ones_run;
            r_byte_shift      <= n_byte_shift;
            r_bit_in_byte     <= n_bit_in_byte;
            r_byte_count      <= n_byte_count;
            r_stuffed_bits    <= n_stuffed_bits;
            r_address_differs <= n_address_differs;
            r_last_four       <= n_last_four;
        end
    end

endmodule

// ===== hw/rtl/bit_stuffed_frame_receiver_core.sv =====
// Channel   Dir  Beat payload                                          Handshake
// i_bit     in   line_bit                                              valid/ready
// o_res     out  result_kind, data_byte, byte_index, frame_status,
//                frame_bytes                                           valid/ready
// i_cfg     in   index (0 station_address, 1 min_frame_bits), data     valid/ready
//
// One line bit per cycle: a beat is taken every clock unless the result
// register holds a beat that the sink is not taking.
// Each bit is processed in the cycle it is accepted; its result, if any,
// shows up on o_res in the next cycle, held in the result register.
// Reset (synchronous, i_rst_n low) clears the deframer and loads the
// register defaults; no clearing pass is needed.
// i_cfg is always ready; writes are meant only while the block is idle.
module bit_stuffed_frame_receiver_core #(
    parameter int unsigned MAX_FRAME_BYTES = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bsfr_bit_if.sink   i_bit,
    bsfr_res_if.source o_res,
    bsfr_cfg_if.sink   i_cfg
);

    // configuration registers
    logic [bsfr_pkg::CFG_DATA_W-1:0] r_station_address;
    logic [10:0]                     r_min_frame_bits;

    // result register between deframer and sink
    logic              r_out_valid, n_out_valid;
    bsfr_pkg::t_result r_out;

    logic              step;
    logic              res_valid;
    bsfr_pkg::t_result res;

    // take a new bit whenever the result register is free or draining
    assign i_bit.ready = !r_out_valid || o_res.ready;
    assign step        = i_bit.valid && i_bit.ready;
    assign i_cfg.ready = 1'b1;

    bsfr_deframer #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_deframer (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (step),
        .i_line_bit        (i_bit.line_bit),
        .i_station_address (r_station_address),
        .i_min_frame_bits  (r_min_frame_bits),
        .o_res_valid       (res_valid),
        .o_res             (res)
    );

    // a step with no result empties the register once the old beat is gone
    assign n_out_valid = step ? res_valid : (r_out_valid && !o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid       <= 1'b0;
            r_station_address <= '0;
            r_min_frame_bits  <= bsfr_pkg::MIN_FRAME_BITS_RESET;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    bsfr_pkg::CFG_STATION_ADDRESS: r_station_address <= i_cfg.data;
                    bsfr_pkg::CFG_MIN_FRAME_BITS:  r_min_frame_bits  <= i_cfg.data[10:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.result_kind  = r_out.result_kind;
    assign o_res.data_byte    = r_out.data_byte;
    assign o_res.byte_index   = r_out.byte_index;
    assign o_res.frame_status = r_out.frame_status;
    assign o_res.frame_bytes  = r_out.frame_bytes;

endmodule
